/* rtl/ptt_pkg.sv */
// Shared types, codes and constants for the push-to-talk controller.
package ptt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int HOLD_BITS   = 32;
    localparam int COOL_BITS   = 16;
    localparam int PRESS_BITS  = 32;
    localparam int SCNT_BITS   = 48;
    localparam int REQ_BITS    = 3;
    localparam int MODE_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam int OUT_BITS = MODE_BITS + 4 + SAMPLE_BITS + HOLD_BITS + PRESS_BITS + SCNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = ((REQ_BITS + 7) / 8) * 8;

    localparam logic [REQ_BITS-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PRESS   = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_RELEASE = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_TOGGLE  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_SAMPLE  = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR   = 3'd5;

    localparam logic [MODE_BITS-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TX   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_COOL = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_HOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BEEP_EN  = 2'd3;

    typedef struct packed {
        logic                  enable;
        logic [COOL_BITS-1:0]  min_hold;
        logic [COOL_BITS-1:0]  cooldown;
        logic                  beep_en;
    } t_cfg;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [HOLD_BITS-1:0]  hold;
        logic [COOL_BITS-1:0]  cool;
        logic [PRESS_BITS-1:0] press;
        logic [SCNT_BITS-1:0]  samples;
    } t_state;

    typedef struct packed {
        logic [SCNT_BITS-1:0]          sample_count;
        logic [PRESS_BITS-1:0]         transmission_count;
        logic [HOLD_BITS-1:0]          hold_time;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          sample_valid;
        logic                          debounced;
        logic                          beep;
        logic                          mode_changed;
        logic [MODE_BITS-1:0]          mode;
    } t_result;

endpackage

/* rtl/ptt_step.sv */
// Next-state and result logic for one request beat.
module ptt_step (
    input  ptt_pkg::t_cfg                         i_cfg,
    input  ptt_pkg::t_state                       i_state,
    input  logic [ptt_pkg::REQ_BITS-1:0]          i_req,
    input  logic signed [ptt_pkg::SAMPLE_BITS-1:0] i_sample,
    output ptt_pkg::t_state                       o_state,
    output ptt_pkg::t_result                      o_result
);
    import ptt_pkg::*;

    logic [COOL_BITS-1:0] cool_inc;
    logic                 is_press;
    logic                 is_release;
    logic                 beep;
    logic                 deb;
    logic                 valid;
    t_state               nxt;

    assign cool_inc   = (i_state.cool != '1) ? i_state.cool + 1'b1 : i_state.cool;
    assign is_press   = (i_req == REQ_PRESS) || (i_req == REQ_TOGGLE && i_state.mode == MODE_IDLE);
    assign is_release = (i_req == REQ_RELEASE) || (i_req == REQ_TOGGLE && i_state.mode == MODE_TX);

    always_comb begin
        nxt   = i_state;
        beep  = 1'b0;
        deb   = 1'b0;
        valid = 1'b0;
        priority if (i_req == REQ_TICK) begin
            if (i_state.mode == MODE_TX) begin
                if (i_state.hold != '1) begin
                    nxt.hold = i_state.hold + 1'b1;
                end
            end else if (i_state.mode == MODE_COOL && i_cfg.enable) begin
                nxt.cool = cool_inc;
                if (cool_inc >= i_cfg.cooldown) begin
                    nxt.mode = MODE_IDLE;
                end
            end
        end else if (is_press) begin
            if (i_cfg.enable && i_state.mode == MODE_IDLE) begin
                nxt.mode = MODE_TX;
                nxt.hold = '0;
                if (i_state.press != '1) begin
                    nxt.press = i_state.press + 1'b1;
                end
                beep = i_cfg.beep_en;
            end
        end else if (is_release) begin
            if (i_cfg.enable && i_state.mode == MODE_TX) begin
                if (i_state.hold < {{(HOLD_BITS-COOL_BITS){1'b0}}, i_cfg.min_hold}) begin
                    nxt.mode = MODE_IDLE;
                    deb      = 1'b1;
                end else begin
                    nxt.mode = MODE_COOL;
                    nxt.cool = '0;
                    beep     = i_cfg.beep_en;
                end
            end
        end else if (i_req == REQ_SAMPLE) begin
            if (i_state.mode == MODE_TX) begin
                valid = 1'b1;
                if (i_state.samples != '1) begin
                    nxt.samples = i_state.samples + 1'b1;
                end
            end
        end else if (i_req == REQ_CLEAR) begin
            nxt.press   = '0;
            nxt.samples = '0;
        end else begin
            nxt = i_state;
        end
    end

    assign o_state = nxt;

    assign o_result.mode               = nxt.mode;
    assign o_result.mode_changed       = (nxt.mode != i_state.mode);
    assign o_result.beep               = beep;
    assign o_result.debounced          = deb;
    assign o_result.sample_valid       = valid;
    assign o_result.sample_out         = valid ? i_sample : '0;
    assign o_result.hold_time          = (nxt.mode == MODE_IDLE) ? '0 : nxt.hold;
    assign o_result.transmission_count = nxt.press;
    assign o_result.sample_count       = nxt.samples;

endmodule

/* rtl/push_to_talk_controller_core.sv */
// Push-to-talk controller top level: configuration, state and result registers.
// The result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle unless the output stalls; the state update is a single pass.
// A new beat is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) sets mode idle, clears timers and counters,
// and loads register defaults (enable 0, beep_enable 1).
module push_to_talk_controller_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ptt_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [ptt_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_in
    input  logic [ptt_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // req_type
    input  logic [ptt_pkg::IN_USER_BITS-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // mode, mode_changed, beep, debounced, sample_valid, sample_out,
    // hold_time, transmission_count, sample_count
    output logic [ptt_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);
    import ptt_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.min_hold <= '0;
            r_cfg.cooldown <= '0;
            r_cfg.beep_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                CFG_MIN_HOLD: r_cfg.min_hold <= i_cfg_data[COOL_BITS-1:0];
                CFG_COOLDOWN: r_cfg.cooldown <= i_cfg_data[COOL_BITS-1:0];
                CFG_BEEP_EN:  r_cfg.beep_en  <= i_cfg_data[0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    ptt_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_req    (s_axis_tuser[REQ_BITS-1:0]),
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= MODE_IDLE;
            r_state.hold    <= '0;
            r_state.cool    <= '0;
            r_state.press   <= '0;
            r_state.samples <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-OUT_BITS){1'b0}}, r_result};

endmodule
